[src/u8sd_pkg.sv]
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

    localparam int POSITION_BITS = 32;  // internal byte position counter
    localparam int POS_OUT_BITS  = 32;  // byte_position port width
    localparam int CP_BITS       = 21;
    localparam int BYTE_BITS     = 8;
    localparam int PAYLOAD_BITS  = 7;   // largest payload of a single byte
    localparam int QDEPTH        = 2;   // power of two
    localparam int QPTR_BITS     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EXPECT_CONT = 2'd1,
        ST_BAD_START   = 2'd2,
        ST_TRUNCATED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CL_ASCII = 2'd0,
        CL_LEAD  = 2'd1,
        CL_CONT  = 2'd2,
        CL_BAD   = 2'd3
    } byte_class_t;

    // classified request as it travels from front to back
    typedef struct packed {
        byte_class_t              cls;
        logic [1:0]               need;
        logic [PAYLOAD_BITS-1:0]  payload;
        logic [POS_OUT_BITS-1:0]  pos;
        logic                     last;
    } req_t;

endpackage

[src/u8sd_front.sv]
// ----------------------------------------------------------------------------
// u8sd_front
// Accepts bytes, classifies them and tags each with its string position.
// ----------------------------------------------------------------------------
module u8sd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic [u8sd_pkg::BYTE_BITS-1:0] data_byte,
    input  logic                          end_of_string,
    input  logic                          q_full,
    output logic                          push,
    output u8sd_pkg::req_t                push_req
);
    import u8sd_pkg::*;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;

    assign byte_stall = q_full;
    assign push       = byte_valid && !q_full;

    always_comb
    begin
        push_req.pos  = POS_OUT_BITS'(pos_reg);
        push_req.last = end_of_string;
        push_req.need = 2'd0;
        if (data_byte[7] == 1'b0)
        begin
            push_req.cls     = CL_ASCII;
            push_req.payload = data_byte[6:0];
        end
        else if (data_byte[6] == 1'b0)
        begin
            push_req.cls     = CL_CONT;
            push_req.payload = {1'b0, data_byte[5:0]};
        end
        else if (data_byte[5] == 1'b0)
        begin
            push_req.cls     = CL_LEAD;
            push_req.need    = 2'd1;
            push_req.payload = {2'b00, data_byte[4:0]};
        end
        else if (data_byte[4] == 1'b0)
        begin
            push_req.cls     = CL_LEAD;
            push_req.need    = 2'd2;
            push_req.payload = {3'b000, data_byte[3:0]};
        end
        else if (data_byte[3] == 1'b0)
        begin
            push_req.cls     = CL_LEAD;
            push_req.need    = 2'd3;
            push_req.payload = {4'b0000, data_byte[2:0]};
        end
        else
        begin
            push_req.cls     = CL_BAD;
            push_req.payload = '0;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
            pos_next = end_of_string ? '0 : pos_reg + POSITION_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

[src/u8sd_queue.sv]
// ----------------------------------------------------------------------------
// u8sd_queue
// Short register queue between the classifier and the decoder.
// ----------------------------------------------------------------------------
module u8sd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u8sd_pkg::req_t push_req,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output u8sd_pkg::req_t head
);
    import u8sd_pkg::*;

    req_t                 entry_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign full      = (count_reg == QCNT_BITS'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_BITS'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_BITS'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_req;
    end

endmodule

[src/u8sd_back.sv]
// ----------------------------------------------------------------------------
// u8sd_back
// Sequence decoder: tracks pending continuations, builds code points and
// drives the result register.
// ----------------------------------------------------------------------------
module u8sd_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_not_empty,
    input  u8sd_pkg::req_t                    head,
    output logic                              pop,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [u8sd_pkg::CP_BITS-1:0]      code_point,
    output logic [1:0]                        status,
    output logic [u8sd_pkg::POS_OUT_BITS-1:0] byte_position,
    output logic                              string_done
);
    import u8sd_pkg::*;

    logic [1:0]         rem_reg;
    logic [1:0]         rem_next;
    logic [CP_BITS-1:0] acc_reg;
    logic [CP_BITS-1:0] acc_next;
    logic [CP_BITS-1:0] acc_shift;
    logic [1:0]         rem_dec;

    logic               valid_reg;
    logic               valid_next;
    logic [CP_BITS-1:0] cp_reg;
    status_t            st_reg;
    logic [POS_OUT_BITS-1:0] pos_reg;
    logic               done_reg;

    logic               emit;
    logic [CP_BITS-1:0] emit_cp;
    status_t            emit_st;

    // output register free, or emptied this cycle
    assign pop = q_not_empty && (!valid_reg || !result_stall);

    assign acc_shift = {acc_reg[CP_BITS-7:0], head.payload[5:0]};
    assign rem_dec   = rem_reg - 2'd1;

    always_comb
    begin
        rem_next = rem_reg;
        acc_next = acc_reg;
        emit     = 1'b0;
        emit_cp  = '0;
        emit_st  = ST_OK;
        if (pop)
        begin
            if (rem_reg != 2'd0)
            begin
                if (head.cls != CL_CONT)
                begin
                    emit     = 1'b1;
                    emit_st  = ST_EXPECT_CONT;
                    rem_next = 2'd0;
                    acc_next = '0;
                end
                else if (rem_dec == 2'd0)
                begin
                    emit     = 1'b1;
                    emit_cp  = acc_shift;
                    rem_next = 2'd0;
                    acc_next = '0;
                end
                else if (head.last)
                begin
                    emit     = 1'b1;
                    emit_st  = ST_TRUNCATED;
                    rem_next = 2'd0;
                    acc_next = '0;
                end
                else
                begin
                    rem_next = rem_dec;
                    acc_next = acc_shift;
                end
            end
            else
            begin
                unique case (head.cls) inside
                    CL_ASCII:
                    begin
                        emit    = 1'b1;
                        emit_cp = CP_BITS'(head.payload);
                    end
                    CL_LEAD:
                    begin
                        if (head.last)
                        begin
                            emit    = 1'b1;
                            emit_st = ST_TRUNCATED;
                        end
                        else
                        begin
                            rem_next = head.need;
                            acc_next = CP_BITS'(head.payload);
                        end
                    end
                    CL_CONT, CL_BAD:
                    begin
                        emit    = 1'b1;
                        emit_st = ST_BAD_START;
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (emit)
            valid_next = 1'b1;
        else if (!result_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= 2'd0;
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cp_reg   <= emit_cp;
            st_reg   <= emit_st;
            pos_reg  <= head.pos;
            done_reg <= head.last;
        end
    end

    assign result_valid  = valid_reg;
    assign code_point    = cp_reg;
    assign status        = st_reg;
    assign byte_position = pos_reg;
    assign string_done   = done_reg;

endmodule

[src/utf8_stream_decoder_unit.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// UTF-8 byte stream to code point decoder with error reporting.
// ----------------------------------------------------------------------------
// Byte channel: byte_valid/byte_stall carry one encoded byte per request,
// end_of_string set on the last byte of each string.
// Result channel: result_valid/result_stall carry code_point, status,
// byte_position and string_done; a request is made for every finished
// sequence, every error and every final byte of a string.
// Throughput: one byte per cycle while result_stall is low, limited by the
// decoder taking one queue entry per cycle. An accepted byte is written into
// the queue, and its result is then registered in the output register.
// Lead bytes and non-final continuation bytes give no result unless they
// end a string or a lead byte breaks a pending sequence. Reset clears the
// position counter, the pending sequence state, the queue and the result
// valid flag. While the receiver stalls, the result holds; the two-entry
// queue keeps taking bytes until it fills, then byte_stall rises.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              byte_valid,
    output logic                              byte_stall,
    input  logic [u8sd_pkg::BYTE_BITS-1:0]    data_byte,
    input  logic                              end_of_string,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [u8sd_pkg::CP_BITS-1:0]      code_point,
    output logic [1:0]                        status,
    output logic [u8sd_pkg::POS_OUT_BITS-1:0] byte_position,
    output logic                              string_done
);
    import u8sd_pkg::*;

    logic q_full;
    logic q_not_empty;
    logic push;
    logic pop;
    req_t push_req;
    req_t head;

    u8sd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .push          (push),
        .push_req      (push_req)
    );

    u8sd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head      (head)
    );

    u8sd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .head          (head),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .code_point    (code_point),
        .status        (status),
        .byte_position (byte_position),
        .string_done   (string_done)
    );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 stream decoder: a queue of encoded
// strings (directed corner cases, then random well-formed and broken
// sequences) is driven under random idling and stalling, and every result
// is compared field by field with a behavioral decoder kept in step.
// ----------------------------------------------------------------------------
module testbench;

    import u8sd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 1500;
    localparam int QUIET_FROM   = 800;
    localparam int QUIET_TO     = 1300;

    typedef struct {
        logic [7:0] b;
        logic       eos;
    } byte_item_t;

    typedef struct {
        logic [CP_BITS-1:0]      cp;
        status_t                 st;
        logic [POS_OUT_BITS-1:0] pos;
        logic                    done;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic [BYTE_BITS-1:0] data_byte = '0;
    logic end_of_string = 1'b0;
    logic result_stall = 1'b0;
    logic byte_stall;
    logic result_valid;
    logic [CP_BITS-1:0] code_point;
    logic [1:0] status;
    logic [POS_OUT_BITS-1:0] byte_position;
    logic string_done;

    byte_item_t pending_bytes[$];
    decoded_t expected_results[$];
    int total_bytes = 0;
    int accepted_bytes = 0;
    int error_count = 0;
    int cycle_count = 0;
    int idle_cycles = 0;

    // decoder state mirrored by the predictor
    logic [1:0] cont_left = '0;
    logic [CP_BITS-1:0] cp_acc = '0;
    logic [POSITION_BITS-1:0] byte_index = '0;

    utf8_stream_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .code_point    (code_point),
        .status        (status),
        .byte_position (byte_position),
        .string_done   (string_done)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    wire quiet = (cycle_count >= QUIET_FROM) && (cycle_count < QUIET_TO);

    // Predict the result (if any) of one accepted byte.
    task automatic decode_byte(input logic [7:0] b, input logic eos);
        decoded_t r;
        logic emit;
        logic [1:0] need;
        begin
            emit = 1'b0;
            need = 2'd0;
            r.cp = '0;
            r.st = ST_OK;
            r.pos = byte_index[POS_OUT_BITS-1:0];
            r.done = eos;
            if (cont_left != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    emit = 1'b1;
                    r.st = ST_EXPECT_CONT;
                    cont_left = 2'd0;
                    cp_acc = '0;
                end
                else
                begin
                    cp_acc = {cp_acc[CP_BITS-7:0], b[5:0]};
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0)
                    begin
                        emit = 1'b1;
                        r.cp = cp_acc;
                        cp_acc = '0;
                    end
                    else if (eos)
                    begin
                        emit = 1'b1;
                        r.st = ST_TRUNCATED;
                        cont_left = 2'd0;
                        cp_acc = '0;
                    end
                end
            end
            else
            begin
                if (!b[7])
                begin
                    emit = 1'b1;
                    r.cp = CP_BITS'(b);
                end
                else if (b[7:5] == 3'b110)
                begin
                    cp_acc = CP_BITS'(b[4:0]);
                    need = 2'd1;
                end
                else if (b[7:4] == 4'b1110)
                begin
                    cp_acc = CP_BITS'(b[3:0]);
                    need = 2'd2;
                end
                else if (b[7:3] == 5'b11110)
                begin
                    cp_acc = CP_BITS'(b[2:0]);
                    need = 2'd3;
                end
                else
                begin
                    emit = 1'b1;
                    r.st = ST_BAD_START;
                    cp_acc = '0;
                end
                if (need != 2'd0)
                begin
                    if (eos)
                    begin
                        emit = 1'b1;
                        r.st = ST_TRUNCATED;
                        cp_acc = '0;
                    end
                    else
                        cont_left = need;
                end
            end
            byte_index = eos ? '0 : byte_index + 1'b1;
            if (emit)
                expected_results.push_back(r);
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic eos);
        byte_item_t it;
        begin
            it.b = b;
            it.eos = eos;
            pending_bytes.push_back(it);
            total_bytes++;
        end
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        begin
            r = 8'($urandom_range(0, 255));
            case (len)
                1: r[7] = 1'b0;
                2: r[7:5] = 3'b110;
                3: r[7:4] = 4'b1110;
                default: r[7:3] = 5'b11110;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // Random string: mostly well-formed characters, some noise and broken ones.
    task automatic add_string(input int nchars);
        int kind;
        int len;
        int k;
        logic [7:0] b;
        begin
            for (int i = 0; i < nchars; i++)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 70)
                begin
                    len = $urandom_range(1, 4);
                    add_byte(lead_byte(len), 1'b0);
                    for (int j = 1; j < len; j++)
                        add_byte(cont_byte(), 1'b0);
                end
                else if (kind < 80)
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                else if (kind < 92)
                begin
                    // lead followed by too few continuations, then a non-continuation
                    len = $urandom_range(2, 4);
                    k = $urandom_range(0, len - 2);
                    add_byte(lead_byte(len), 1'b0);
                    for (int j = 0; j < k; j++)
                        add_byte(cont_byte(), 1'b0);
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == 2'b10)
                        b[6] = 1'b1;
                    add_byte(b, 1'b0);
                end
                else if (kind < 96)
                    add_byte(cont_byte(), 1'b0);
                else
                begin
                    // unfinished sequence, truncated if the string ends here
                    len = $urandom_range(2, 4);
                    k = $urandom_range(0, len - 2);
                    add_byte(lead_byte(len), 1'b0);
                    for (int j = 0; j < k; j++)
                        add_byte(cont_byte(), 1'b0);
                end
            end
            pending_bytes[$].eos = 1'b1;
        end
    endtask

    initial
    begin
        // a single-byte string and one of each sequence length
        add_byte(8'h00, 1'b1);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hC2, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h9F, 1'b0);
        add_byte(8'h98, 1'b0);
        add_byte(8'h80, 1'b0);
        // largest code point, then an encoded zero at the end of the string
        add_byte(8'hF7, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b1);
        // invalid starts, missing continuation, decoding resumes after
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hF8, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hA9, 1'b1);
        // truncated on a continuation, on a lead, missing continuation at end
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        add_byte(8'hC3, 1'b1);
        add_byte(8'hC2, 1'b0);
        add_byte(8'h41, 1'b1);

        add_string(150);
        while (total_bytes < RANDOM_BYTES)
            add_string($urandom_range(1, 10));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_bytes < total_bytes || expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // byte channel driver and result stall generator
    always @(posedge clk or negedge rst_n)
    begin
        byte_item_t it;
        logic go;
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            data_byte <= '0;
            end_of_string <= 1'b0;
            result_stall <= 1'b0;
        end
        else
        begin
            result_stall <= !quiet && ($urandom_range(0, 99) < 31);
            go = quiet || ($urandom_range(0, 99) >= 31);
            if (!byte_valid || !byte_stall)
            begin
                if (go && pending_bytes.size() != 0)
                begin
                    it = pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    data_byte <= it.b;
                    end_of_string <= it.eos;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // monitor: check the accepted result, then predict the accepted byte
    always @(posedge clk)
    begin
        decoded_t e;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result cp=%h status=%0d pos=%0d done=%b",
                             $time, code_point, status, byte_position, string_done);
                    error_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (code_point !== e.cp)
                    begin
                        $display("%0t: code_point expected %h actual %h",
                                 $time, e.cp, code_point);
                        error_count++;
                    end
                    if (status !== e.st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.st, status);
                        error_count++;
                    end
                    if (byte_position !== e.pos)
                    begin
                        $display("%0t: byte_position expected %0d actual %0d",
                                 $time, e.pos, byte_position);
                        error_count++;
                    end
                    if (string_done !== e.done)
                    begin
                        $display("%0t: string_done expected %b actual %b",
                                 $time, e.done, string_done);
                        error_count++;
                    end
                end
            end
            if (byte_valid && !byte_stall)
            begin
                decode_byte(data_byte, end_of_string);
                accepted_bytes++;
            end
        end
    end

    // watchdog on cycles with no request accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d bytes accepted, %0d results outstanding",
                         $time, accepted_bytes, expected_results.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

[filelist.f]
src/u8sd_pkg.sv
src/u8sd_front.sv
src/u8sd_queue.sv
src/u8sd_back.sv
src/utf8_stream_decoder_unit.sv
bench/testbench.sv
